// ----- src/tfd_pkg.sv -----
`timescale 1ns / 1ps

package tfd_pkg;

    // Frame status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
    localparam logic [2:0] ST_HDR_MISMATCH = 3'd2;
    localparam logic [2:0] ST_TRUNCATED   = 3'd3;
    localparam logic [2:0] ST_LEN_LOW     = 3'd4;
    localparam logic [2:0] ST_NO_CHECKSUM = 3'd5;

    // Configuration register indexes
    localparam logic CFG_PROTOCOL_MODE = 1'b0;
    localparam logic CFG_HEADER_KIND   = 1'b1;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Header letters
    localparam logic [23:0] HDR_REQ_LONG  = "WAY";
    localparam logic [23:0] HDR_RPY_LONG  = "DES";
    localparam logic [7:0]  HDR_REQ_SHORT = "P";
    localparam logic [7:0]  HDR_RPY_SHORT = "T";

    localparam int          POS_W   = 17;
    localparam logic [16:0] POS_MAX = 17'h1FFFF;

    localparam int FIFO_DEPTH_DEF = 4;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [7:0]  command_code;
        logic [7:0]  module_code;
        logic [2:0]  frame_status;
        logic [15:0] payload_length;
        logic        last_of_run;
    } t_result;

    // Expected header byte at position idx for the given mode and kind.
    function automatic logic [7:0] hdr_letter(input logic mode, input logic kind,
                                              input logic [1:0] idx);
        logic [23:0] word;
        logic [7:0]  letter;
        word = kind ? HDR_RPY_LONG : HDR_REQ_LONG;
        unique case (idx)
            2'd0:    letter = word[23:16];
            2'd1:    letter = word[15:8];
            default: letter = word[7:0];
        endcase
        if (mode) begin
            letter = kind ? HDR_RPY_SHORT : HDR_REQ_SHORT;
        end
        return letter;
    endfunction

endpackage

// ----- src/tester_frame_deframer_core.sv -----
`timescale 1ns / 1ps

// Frame deframer: takes a received buffer one byte per transaction, with
// i_buffer_end marking its last byte. It checks the mode-dependent header
// ("WAY"/"DES" with a trailing checksum, or "P"/"T" with a length that
// excludes the prefix), reads the 16-bit big-endian length, captures the
// module and command bytes, and forwards each payload byte as a payload
// result, queued in the result FIFO. The last byte of a buffer also yields
// a status result (error code, command, module, payload count); when the
// status is not ok the consumer must drop the payload bytes already seen.
// All byte work is one compare and counter update, so one byte is accepted
// every clock while o_in_stall is low; results queue in a FIFO_DEPTH-entry
// result FIFO, and o_in_stall rises only when fewer than two free slots
// remain, i.e. when the output side has been stalled or a byte produced two
// results while the queue was already busy.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data and
// takes effect on the next byte.

module tester_frame_deframer_core #(
    parameter int FIFO_DEPTH = tfd_pkg::FIFO_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,
    // byte input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_buffer_end,
    // result output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_command_code,
    output logic [7:0]  o_module_code,
    output logic [2:0]  o_frame_status,
    output logic [15:0] o_payload_length,
    output logic        o_last_of_run
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration registers
    logic r_mode;
    logic r_kind;

    // Per-buffer parse state
    logic [16:0] r_pos, n_pos;
    logic        r_hm, n_hm;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_mod, n_mod;
    logic [15:0] r_pcnt, n_pcnt;

    // Result FIFO
    tfd_pkg::t_result   r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_count, n_count;

    logic               in_accept;
    logic               out_pop;
    logic               emit_payload;
    logic [16:0]        hlen, mod_idx, cmd_idx, cnt;
    logic [15:0]        tot;
    logic signed [17:0] dl;
    logic [2:0]         status;
    logic [7:0]         cap_cmd, cap_mod;
    tfd_pkg::t_result   res_payload, res_status, res_first;
    logic [1:0]         push_n;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_pop    = o_out_valid && !i_out_stall;
    // Keep room for the two results a single byte may produce.
    assign o_in_stall = r_count > CNT_W'(FIFO_DEPTH - 2);

    // Parse: position-dependent header check, length and field capture.
    always_comb begin
        hlen    = r_mode ? 17'd1 : 17'd3;
        mod_idx = r_mode ? 17'd5 : 17'd6;
        cmd_idx = r_mode ? 17'd6 : 17'd7;

        n_hm = r_hm;
        if (r_pos < hlen &&
            i_data_byte != tfd_pkg::hdr_letter(r_mode, r_kind, r_pos[1:0])) begin
            n_hm = 1'b0;
        end

        n_len = r_len;
        if (r_pos == hlen) begin
            n_len = {i_data_byte, 8'h00};
        end else if (r_pos == hlen + 17'd1) begin
            n_len = {r_len[15:8], i_data_byte};
        end

        // Captured module and command as they stand after this byte.
        cap_mod = (r_pos == mod_idx) ? i_data_byte : r_mod;
        cap_cmd = (r_pos == cmd_idx) ? i_data_byte : r_cmd;
        n_mod   = cap_mod;
        n_cmd   = cap_cmd;

        // Frame total and payload count (may go negative).
        tot = r_mode ? n_len + 16'd1 : n_len;
        dl  = $signed({2'b00, tot}) - (r_mode ? 18'sd7 : 18'sd9);

        emit_payload = (r_pos > cmd_idx) && (dl > 18'sd0) &&
                       ($signed({2'b00, r_pcnt}) < dl);
        n_pcnt = emit_payload ? r_pcnt + 16'd1 : r_pcnt;

        // Saturating byte count.
        cnt = (r_pos == tfd_pkg::POS_MAX) ? tfd_pkg::POS_MAX : r_pos + 17'd1;

        // Status in priority order.
        if (cnt < hlen + 17'd2) begin
            status = tfd_pkg::ST_TOO_SHORT;
        end else if (!n_hm) begin
            status = tfd_pkg::ST_HDR_MISMATCH;
        end else if (cnt < {1'b0, tot}) begin
            status = tfd_pkg::ST_TRUNCATED;
        end else if (cmd_idx >= {1'b0, tot}) begin
            status = tfd_pkg::ST_LEN_LOW;
        end else if (dl < 18'sd0) begin
            status = tfd_pkg::ST_NO_CHECKSUM;
        end else begin
            status = tfd_pkg::ST_OK;
        end

        // Return to the idle frame state after the buffer end.
        n_pos = cnt;
        if (i_buffer_end) begin
            n_pos  = '0;
            n_hm   = 1'b1;
            n_len  = '0;
            n_mod  = '0;
            n_cmd  = '0;
            n_pcnt = '0;
        end
    end

    // Build the result entries for this byte.
    always_comb begin
        res_payload                = '0;
        res_payload.kind           = tfd_pkg::KIND_PAYLOAD;
        res_payload.payload_byte   = i_data_byte;
        res_payload.last_of_run    = !i_buffer_end;

        res_status                 = '0;
        res_status.kind            = tfd_pkg::KIND_STATUS;
        res_status.frame_status    = status;
        res_status.last_of_run     = 1'b1;
        if (status == tfd_pkg::ST_OK) begin
            res_status.command_code   = cap_cmd;
            res_status.module_code    = cap_mod;
            res_status.payload_length = dl[15:0];
        end

        res_first = emit_payload ? res_payload : res_status;
        push_n    = in_accept ? {1'b0, emit_payload} + {1'b0, i_buffer_end} : 2'd0;
    end

    assign n_count = r_count + CNT_W'(push_n) - CNT_W'(out_pop);

    // Control and parse state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_kind  <= 1'b0;
            r_pos   <= '0;
            r_hm    <= 1'b1;
            r_len   <= '0;
            r_cmd   <= '0;
            r_mod   <= '0;
            r_pcnt  <= '0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tfd_pkg::CFG_PROTOCOL_MODE: r_mode <= i_cfg_data;
                    default:                    r_kind <= i_cfg_data;
                endcase
            end
            if (in_accept) begin
                r_pos  <= n_pos;
                r_hm   <= n_hm;
                r_len  <= n_len;
                r_cmd  <= n_cmd;
                r_mod  <= n_mod;
                r_pcnt <= n_pcnt;
            end
            // Advance pointers by the number of results pushed / popped.
            r_wr    <= r_wr + PTR_W'(push_n);
            r_rd    <= r_rd + PTR_W'(out_pop);
            r_count <= n_count;
        end
    end

    // Result storage: write the first result, and the status behind it
    // when the byte also closed the buffer inside the payload.
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr] <= res_first;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr + PTR_W'(1)] <= res_status;
        end
    end

    assign o_out_valid      = r_count != '0;
    assign o_result_kind    = r_fifo[r_rd].kind;
    assign o_payload_byte   = r_fifo[r_rd].payload_byte;
    assign o_command_code   = r_fifo[r_rd].command_code;
    assign o_module_code    = r_fifo[r_rd].module_code;
    assign o_frame_status   = r_fifo[r_rd].frame_status;
    assign o_payload_length = r_fifo[r_rd].payload_length;
    assign o_last_of_run    = r_fifo[r_rd].last_of_run;

    // Accepting a byte always leaves room for both of its results.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> r_count <= CNT_W'(FIFO_DEPTH - 2))
        else $error("result FIFO could overflow");

    // A status result always closes the run of its byte.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == tfd_pkg::KIND_STATUS) |-> o_last_of_run)
        else $error("status result not marked last");

    // The buffer end returns the parser to the start of a frame.
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_buffer_end) |=> (r_pos == '0 && r_hm && r_pcnt == '0))
        else $error("frame state not cleared after buffer end");

    // Payload results carry no status.
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == tfd_pkg::KIND_PAYLOAD)
            |-> (o_frame_status == tfd_pkg::ST_OK && o_payload_length == '0))
        else $error("payload result carries status fields");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for tester_frame_deframer_core.
module tb;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 4;       // slack after the last expected result
    localparam int DRAIN_CYCLES    = 16;
    localparam int HOLD_CYCLES     = 300;     // long receiver hold-off, fills the result FIFO
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 98;      // about 1250 bytes in total with the table
    localparam int HOLD_PHASE      = 3;
    localparam int CALM_PHASE      = 6;       // no idling on either side
    localparam int CYCLE_LIMIT     = 1500000;

    // One row of the directed table: register setting, the byte, and an
    // optional pinned status for rows whose outcome is obvious by eye.
    typedef struct packed {
        logic       mode;
        logic       kind;
        logic [7:0] data;
        logic       last;
        logic       pinned;
        logic [2:0] code;
    } t_dir_row;

    localparam int DIR_COUNT = 26;
    localparam t_dir_row DIR_ROWS [DIR_COUNT] = '{
        // three-letter request: a lone byte is too short
        '{1'b0, 1'b0, "W",   1'b1, 1'b1, tfd_pkg::ST_TOO_SHORT},
        // one-letter request, length 7 -> one payload byte on the buffer's last byte
        '{1'b1, 1'b0, "P",   1'b0, 1'b0, tfd_pkg::ST_OK},
        '{1'b1, 1'b0, 8'h00, 1'b0, 1'b0, tfd_pkg::ST_OK},
        '{1'b1, 1'b0, 8'h07, 1'b0, 1'b0, tfd_pkg::ST_OK},
        '{1'b1, 1'b0, 8'hFF, 1'b0, 1'b0, tfd_pkg::ST_OK},
        '{1'b1, 1'b0, 8'h00, 1'b0, 1'b0, tfd_pkg::ST_OK},
        '{1'b1, 1'b0, 8'h00, 1'b0, 1'b0, tfd_pkg::ST_OK},   // module
        '{1'b1, 1'b0, 8'hFF, 1'b0, 1'b0, tfd_pkg::ST_OK},   // command
        '{1'b1, 1'b0, 8'hFF, 1'b1, 1'b0, tfd_pkg::ST_OK},   // payload, then status
        // one-letter reply, frame needs 5 bytes but buffer ends at 3
        '{1'b1, 1'b1, "T",   1'b0, 1'b0, tfd_pkg::ST_OK},
        '{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, tfd_pkg::ST_OK},
        '{1'b1, 1'b1, 8'h04, 1'b1, 1'b1, tfd_pkg::ST_TRUNCATED},
        // request letter while a reply is expected
        '{1'b1, 1'b1, "P",   1'b0, 1'b0, tfd_pkg::ST_OK},
        '{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, tfd_pkg::ST_OK},
        '{1'b1, 1'b1, 8'h80, 1'b1, 1'b1, tfd_pkg::ST_HDR_MISMATCH},
        // length 0xFFFF wraps to zero in one-letter mode
        '{1'b1, 1'b1, "T",   1'b0, 1'b0, tfd_pkg::ST_OK},
        '{1'b1, 1'b1, 8'hFF, 1'b0, 1'b0, tfd_pkg::ST_OK},
        '{1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, tfd_pkg::ST_LEN_LOW},
        // three-letter reply, length 8 leaves no byte for the checksum
        '{1'b0, 1'b1, "D",   1'b0, 1'b0, tfd_pkg::ST_OK},
        '{1'b0, 1'b1, "E",   1'b0, 1'b0, tfd_pkg::ST_OK},
        '{1'b0, 1'b1, "S",   1'b0, 1'b0, tfd_pkg::ST_OK},
        '{1'b0, 1'b1, 8'h00, 1'b0, 1'b0, tfd_pkg::ST_OK},
        '{1'b0, 1'b1, 8'h08, 1'b0, 1'b0, tfd_pkg::ST_OK},
        '{1'b0, 1'b1, 8'h5A, 1'b0, 1'b0, tfd_pkg::ST_OK},
        '{1'b0, 1'b1, 8'hA5, 1'b0, 1'b0, tfd_pkg::ST_OK},
        '{1'b0, 1'b1, 8'h3C, 1'b1, 1'b1, tfd_pkg::ST_NO_CHECKSUM}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic        i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_buffer_end;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_result_kind;
    logic [7:0]  o_payload_byte;
    logic [7:0]  o_command_code;
    logic [7:0]  o_module_code;
    logic [2:0]  o_frame_status;
    logic [15:0] o_payload_length;
    logic        o_last_of_run;

    // Side band that travels with each byte: pinned status for directed rows.
    logic        pin_valid;
    logic [2:0]  pin_code;

    // Register copies and per-frame state of the deframer model.
    logic        cfg_mode = 1'b0;
    logic        cfg_kind = 1'b0;
    logic [16:0] fr_pos   = '0;
    logic        fr_hdr_ok = 1'b1;
    logic [15:0] fr_len   = '0;
    logic [7:0]  fr_cmd   = '0;
    logic [7:0]  fr_mod   = '0;
    logic [15:0] fr_sent  = '0;

    tfd_pkg::t_result results_due[$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          bytes_sent  = 0;
    int          holds_asked = 0;
    bit          idle_on     = 1'b1;

    tester_frame_deframer_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_buffer_end    (i_buffer_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_kind   (o_result_kind),
        .o_payload_byte  (o_payload_byte),
        .o_command_code  (o_command_code),
        .o_module_code   (o_module_code),
        .o_frame_status  (o_frame_status),
        .o_payload_length(o_payload_length),
        .o_last_of_run   (o_last_of_run)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Append one expected result at the tail of the queue.
    function automatic void queue_result(input tfd_pkg::t_result r);
        results_due.insert(results_due.size(), r);
    endfunction

    // Advance the frame model by one accepted byte and queue the results it
    // causes: a payload byte inside the payload window, a status at the end.
    function automatic void deframe_byte(input logic [7:0] b, input logic last_b,
                                         input logic pinned, input logic [2:0] pin_st);
        int          hdr_len;
        int          mod_pos;
        int          cmd_pos;
        int          pos;
        int          tot;
        int          room;
        logic [23:0] word;
        logic [7:0]  want;
        logic [15:0] tot16;
        logic [2:0]  st;
        tfd_pkg::t_result r;
        hdr_len = cfg_mode ? 1 : 3;
        mod_pos = cfg_mode ? 5 : 6;
        cmd_pos = mod_pos + 1;
        pos     = int'(fr_pos);

        // Header letters, then the big-endian length; the high byte clears the low one.
        if (pos < hdr_len) begin
            if (cfg_mode) begin
                want = cfg_kind ? tfd_pkg::HDR_RPY_SHORT : tfd_pkg::HDR_REQ_SHORT;
            end else begin
                word = cfg_kind ? tfd_pkg::HDR_RPY_LONG : tfd_pkg::HDR_REQ_LONG;
                want = 8'(word >> (8 * (2 - pos)));
            end
            if (b != want) fr_hdr_ok = 1'b0;
        end else if (pos == hdr_len) begin
            fr_len = {b, 8'h00};
        end else if (pos == hdr_len + 1) begin
            fr_len[7:0] = b;
        end
        if (pos == mod_pos) fr_mod = b;
        if (pos == cmd_pos) fr_cmd = b;

        // One-letter mode counts the prefix byte on top of the length field.
        tot16 = cfg_mode ? fr_len + 16'd1 : fr_len;
        tot   = int'(tot16);
        room  = cfg_mode ? tot - 7 : tot - 9;

        if (pos > cmd_pos && room > 0 && int'(fr_sent) < room) begin
            fr_sent = fr_sent + 16'd1;
            r = '0;
            r.kind         = tfd_pkg::KIND_PAYLOAD;
            r.payload_byte = b;
            r.last_of_run  = !last_b;
            queue_result(r);
        end

        if (fr_pos != tfd_pkg::POS_MAX) fr_pos = fr_pos + 17'd1;

        if (last_b) begin
            if (int'(fr_pos) < hdr_len + 2) st = tfd_pkg::ST_TOO_SHORT;
            else if (!fr_hdr_ok)            st = tfd_pkg::ST_HDR_MISMATCH;
            else if (int'(fr_pos) < tot)    st = tfd_pkg::ST_TRUNCATED;
            else if (cmd_pos >= tot)        st = tfd_pkg::ST_LEN_LOW;
            else if (room < 0)              st = tfd_pkg::ST_NO_CHECKSUM;
            else                            st = tfd_pkg::ST_OK;
            if (pinned) st = pin_st;
            r = '0;
            r.kind         = tfd_pkg::KIND_STATUS;
            r.frame_status = st;
            r.last_of_run  = 1'b1;
            if (st == tfd_pkg::ST_OK) begin
                r.command_code   = fr_cmd;
                r.module_code    = fr_mod;
                r.payload_length = 16'(room);
            end
            queue_result(r);
            // drop all frame state for the next buffer
            fr_pos    = '0;
            fr_hdr_ok = 1'b1;
            fr_len    = '0;
            fr_cmd    = '0;
            fr_mod    = '0;
            fr_sent   = '0;
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_result();
        tfd_pkg::t_result want;
        if (results_due.size() == 0) begin
            $error("result with nothing expected: kind %0d", o_result_kind);
            mismatches++;
        end else begin
            want = results_due.pop_front();
            check_field("result_kind",    16'(want.kind),           16'(o_result_kind));
            check_field("payload_byte",   16'(want.payload_byte),   16'(o_payload_byte));
            check_field("command_code",   16'(want.command_code),   16'(o_command_code));
            check_field("module_code",    16'(want.module_code),    16'(o_module_code));
            check_field("frame_status",   16'(want.frame_status),   16'(o_frame_status));
            check_field("payload_length", want.payload_length,      o_payload_length);
            check_field("last_of_run",    16'(want.last_of_run),    16'(o_last_of_run));
        end
    endfunction

    // Monitor: sample both channels with their pre-edge values. Check the
    // outgoing transaction first; a new byte's results can only show later.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) check_result();
            if (i_in_valid && !o_in_stall)
                deframe_byte(i_data_byte, i_buffer_end, pin_valid, pin_code);
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request so
    // that the result FIFO fills and the block stalls its input.
    initial begin
        int holds_done;
        holds_done = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_done != holds_asked) begin
                holds_done++;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= idle_on && ($urandom_range(99) < 27);
            end
        end
    end

    // Offer one byte, with random idle cycles ahead of it, and hold it until
    // the transaction completes. Valid stays high for the caller's next byte.
    task automatic push_byte(input logic [7:0] b, input logic last_b,
                             input logic pinned, input logic [2:0] code);
        while (idle_on && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_buffer_end <= last_b;
        pin_valid    <= pinned;
        pin_code     <= code;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Drop valid, wait for every expected result, then let the pipe settle
    // so that a register write finds the block idle.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == tfd_pkg::CFG_PROTOCOL_MODE) cfg_mode = val;
        else cfg_kind = val;
        @(posedge i_clk);
    endtask

    // Build one buffer for the current registers: mostly well-formed frames
    // with random content, the rest noise, bad lengths, bad headers and
    // early ends. Now and then flip a register before the payload starts.
    task automatic send_random_frame();
        logic [7:0]  fr[$];
        logic [15:0] len;
        logic [23:0] word;
        logic        flip_idx;
        int          sel;
        int          n_pay;
        int          hdr_len;
        int          cut;
        int          idx;
        int          split_at;
        sel     = $urandom_range(99);
        hdr_len = cfg_mode ? 1 : 3;
        if (sel < 12) begin
            repeat ($urandom_range(1, 12)) fr.insert(fr.size(), 8'($urandom_range(255)));
        end else begin
            n_pay = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
            if (cfg_mode) begin
                fr.insert(fr.size(), cfg_kind ? tfd_pkg::HDR_RPY_SHORT
                                              : tfd_pkg::HDR_REQ_SHORT);
                len = 16'(n_pay + 6);
            end else begin
                word = cfg_kind ? tfd_pkg::HDR_RPY_LONG : tfd_pkg::HDR_REQ_LONG;
                fr.insert(fr.size(), word[23:16]);
                fr.insert(fr.size(), word[15:8]);
                fr.insert(fr.size(), word[7:0]);
                len = 16'(n_pay + 9);
            end
            if (sel < 20)
                len = ($urandom_range(3) == 0) ? 16'($urandom_range(16'hFFFF))
                                               : 16'($urandom_range(0, 20));
            fr.insert(fr.size(), len[15:8]);
            fr.insert(fr.size(), len[7:0]);
            // filler before the module byte, then module, command, payload
            repeat (cfg_mode ? 4 : 3 + n_pay) fr.insert(fr.size(), 8'($urandom_range(255)));
            if (cfg_mode) repeat (n_pay) fr.insert(fr.size(), 8'($urandom_range(255)));
            else fr.insert(fr.size(), 8'($urandom_range(255)));   // checksum, never checked
            if ($urandom_range(99) < 15)
                repeat ($urandom_range(1, 5)) fr.insert(fr.size(), 8'($urandom_range(255)));
            if (sel >= 20 && sel < 28) begin
                idx = $urandom_range(0, hdr_len - 1);
                fr[idx] = fr[idx] ^ 8'($urandom_range(1, 255));
            end else if (sel >= 28 && sel < 40) begin
                cut = $urandom_range(1, fr.size() - 1);
                fr  = fr[0:cut-1];
            end
        end
        split_at = ($urandom_range(11) == 0) ? $urandom_range(1, 6) : 0;
        for (int i = 0; i < fr.size(); i++) begin
            if (split_at != 0 && i == split_at) begin
                quiesce();
                flip_idx = 1'($urandom_range(1));
                write_reg(flip_idx,
                          flip_idx == tfd_pkg::CFG_PROTOCOL_MODE ? !cfg_mode : !cfg_kind);
            end
            push_byte(fr[i], i == fr.size() - 1, 1'b0, tfd_pkg::ST_OK);
        end
    endtask

    initial begin
        t_dir_row   row;
        int         phase_start;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= tfd_pkg::CFG_PROTOCOL_MODE;
        i_cfg_data   <= 1'b0;
        i_in_valid   <= 1'b0;
        i_data_byte  <= 8'h00;
        i_buffer_end <= 1'b0;
        pin_valid    <= 1'b0;
        pin_code     <= tfd_pkg::ST_OK;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: retune only between buffers, with the block idle.
        for (int i = 0; i < DIR_COUNT; i++) begin
            row = DIR_ROWS[i];
            if (row.mode != cfg_mode || row.kind != cfg_kind) begin
                quiesce();
                if (row.mode != cfg_mode) write_reg(tfd_pkg::CFG_PROTOCOL_MODE, row.mode);
                if (row.kind != cfg_kind) write_reg(tfd_pkg::CFG_HEADER_KIND, row.kind);
            end
            push_byte(row.data, row.last, row.pinned, row.code);
        end

        // Random phases: the first four walk all register corners, the calm
        // phase runs with no idling on either side.
        for (int ph = 0; ph < PHASES; ph++) begin
            quiesce();
            write_reg(tfd_pkg::CFG_PROTOCOL_MODE, ph < 4 ? ph[0] : 1'($urandom_range(1)));
            write_reg(tfd_pkg::CFG_HEADER_KIND, ph < 4 ? ph[1] : 1'($urandom_range(1)));
            idle_on = (ph != CALM_PHASE);
            if (ph == HOLD_PHASE) holds_asked++;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < ITEMS_PER_PHASE) send_random_frame();
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/tfd_pkg.sv
src/tester_frame_deframer_core.sv
dv/tb.sv
